### src/rnt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reference-counted node table: shared package
// Command and status codes, fixed field widths and the flag group that the
// slot comparator hands to the sequencer.
// ----------------------------------------------------------------------------
package rnt_pkg;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int NUM_W    = 64;
    localparam int HALF_W   = 32;
    localparam int CNT_W    = 16;
    localparam int SLOT_W   = 6;

    localparam logic [CMD_W-1:0] CMD_ENTER   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ROOT    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_EXISTING = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NEW      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OVER     = 3'd4;

    localparam logic [NUM_W-1:0] ROOT_NUMBER = 64'd1;
    localparam logic [NUM_W-1:0] NUMBER_BIAS = 64'd2;

    // Outcome of comparing one stored slot against the key.
    typedef struct packed {
        logic hit;   // slot is live and holds the key
        logic free;  // slot count is zero
    } t_match_flags;

endpackage

### src/rnt_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot comparator
// Checks one slot read from the table against the key of the current command.
// ----------------------------------------------------------------------------
module rnt_match #(
    parameter int REF_BITS = 16
) (
    input  logic [rnt_pkg::NUM_W-1:0] i_key,
    input  logic [rnt_pkg::NUM_W-1:0] i_slot_num,
    input  logic [REF_BITS-1:0]       i_slot_refs,
    output rnt_pkg::t_match_flags     o_flags
);

    logic w_free;

    assign w_free        = (i_slot_refs == '0);
    assign o_flags.free  = w_free;
    assign o_flags.hit   = !w_free && (i_slot_num == i_key);

endmodule

### src/rnt_count_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reference count unit
// Saturating increment for a hit, or subtraction with an over-release check.
// ----------------------------------------------------------------------------
module rnt_count_unit #(
    parameter int REF_BITS = 16
) (
    input  logic                      i_sub,
    input  logic [REF_BITS-1:0]       i_refs,
    input  logic [rnt_pkg::CNT_W-1:0] i_cnt,
    output logic [REF_BITS-1:0]       o_refs,
    output logic                      o_over
);

    localparam int CW = (REF_BITS > rnt_pkg::CNT_W) ? REF_BITS : rnt_pkg::CNT_W;

    logic [CW-1:0] w_refs_ext;
    logic [CW-1:0] w_cnt_ext;
    logic [CW-1:0] w_diff;

    assign w_refs_ext = CW'(i_refs);
    assign w_cnt_ext  = CW'(i_cnt);
    assign w_diff     = w_refs_ext - w_cnt_ext;

    always_comb begin
        o_over = 1'b0;
        if (i_sub) begin
            o_over = (w_cnt_ext > w_refs_ext);
            o_refs = w_diff[REF_BITS-1:0];
        end else if (i_refs == '1) begin
            o_refs = i_refs;
        end else begin
            o_refs = i_refs + REF_BITS'(1);
        end
    end

endmodule

### src/refcounted_node_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reference-counted node table
// Table of node numbers with reference counts, searched one slot per cycle.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                                 Handshake
//  command   in         i_cmd, i_dir_cluster, i_dir_offset,     start && !busy
//                       i_node_number, i_release_count
//  result    out        o_status, o_slot, o_result_number,      o_done, one cycle
//                       o_refs_after
//
// After reset the block clears every reference count, one slot per cycle, and
// busy stays high until the last count is cleared; no beat is taken before then.
// Enter, get-root and release walk the table through one registered read port,
// one slot per cycle: the walk ends at the first hit, or on a miss once the
// last slot has been compared, and the result beat is then shown on o_done.
// The unused command is answered in the cycle after it is taken.
// Results cannot be stalled; a new command may be taken in the cycle in which
// the previous result beat is shown.
//
// The lowest live slot holding the number wins. A miss on enter or get-root
// allocates the lowest free slot seen during the walk, so allocation is only
// decided once the last slot has been compared.
// ----------------------------------------------------------------------------
module refcounted_node_table #(
    parameter int TABLE_SLOTS = 64,
    parameter int REF_BITS    = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [rnt_pkg::CMD_W-1:0]           i_cmd,
    input  logic [rnt_pkg::HALF_W-1:0]          i_dir_cluster,
    input  logic [rnt_pkg::HALF_W-1:0]          i_dir_offset,
    input  logic [rnt_pkg::NUM_W-1:0]           i_node_number,
    input  logic [rnt_pkg::CNT_W-1:0]           i_release_count,
    output logic                                o_done,
    output logic [rnt_pkg::STATUS_W-1:0]        o_status,
    output logic [rnt_pkg::SLOT_W-1:0]          o_slot,
    output logic [rnt_pkg::NUM_W-1:0]           o_result_number,
    output logic [rnt_pkg::CNT_W-1:0]           o_refs_after
);

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
    // Widths used to take the low bits of the slot index and the count.
    localparam int SXW = (IDX_W > rnt_pkg::SLOT_W) ? IDX_W : rnt_pkg::SLOT_W;
    localparam int RXW = (REF_BITS > rnt_pkg::CNT_W) ? REF_BITS : rnt_pkg::CNT_W;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;

    // Table storage: node numbers are only read for live slots, so they are
    // never cleared; counts are cleared by the pass after reset.
    logic [rnt_pkg::NUM_W-1:0] mem_num  [TABLE_SLOTS];
    logic [REF_BITS-1:0]       mem_refs [TABLE_SLOTS];

    logic [1:0]                     r_state, n_state;
    logic [IDX_W-1:0]               r_idx, n_idx;
    logic [IDX_W-1:0]               r_cmp_idx, n_cmp_idx;
    logic                           r_cmp_vld, n_cmp_vld;
    logic                           r_free_found, n_free_found;
    logic [IDX_W-1:0]               r_free_idx, n_free_idx;
    logic [rnt_pkg::CMD_W-1:0]      r_cmd, n_cmd;
    logic [rnt_pkg::NUM_W-1:0]      r_num, n_num;
    logic [rnt_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic [rnt_pkg::NUM_W-1:0]      r_num_q;
    logic [REF_BITS-1:0]            r_refs_q;

    logic                           r_done, n_done;
    logic [rnt_pkg::STATUS_W-1:0]   r_status, n_status;
    logic [rnt_pkg::SLOT_W-1:0]     r_slot, n_slot;
    logic [rnt_pkg::NUM_W-1:0]      r_res_num, n_res_num;
    logic [rnt_pkg::CNT_W-1:0]      r_refs_after, n_refs_after;

    // Memory write port.
    logic                           w_refs_we;
    logic                           w_num_we;
    logic [IDX_W-1:0]               w_wr_addr;
    logic [REF_BITS-1:0]            w_wr_refs;

    rnt_pkg::t_match_flags          w_flags;
    logic [REF_BITS-1:0]            w_new_refs;
    logic                           w_over;
    logic [IDX_W-1:0]               w_res_idx;
    logic [SXW-1:0]                 w_res_idx_ext;
    logic [REF_BITS-1:0]            w_res_refs;
    logic [RXW-1:0]                 w_res_refs_ext;
    logic [rnt_pkg::NUM_W-1:0]      w_enter_num;

    rnt_match #(
        .REF_BITS (REF_BITS)
    ) u_match (
        .i_key       (r_num),
        .i_slot_num  (r_num_q),
        .i_slot_refs (r_refs_q),
        .o_flags     (w_flags)
    );

    rnt_count_unit #(
        .REF_BITS (REF_BITS)
    ) u_count (
        .i_sub  (r_cmd == rnt_pkg::CMD_RELEASE),
        .i_refs (r_refs_q),
        .i_cnt  (r_cnt),
        .o_refs (w_new_refs),
        .o_over (w_over)
    );

    assign w_enter_num    = {i_dir_cluster, i_dir_offset} + rnt_pkg::NUMBER_BIAS;
    assign w_res_idx_ext  = SXW'(w_res_idx);
    assign w_res_refs_ext = RXW'(w_res_refs);

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_cmp_idx    = r_cmp_idx;
        n_cmp_vld    = r_cmp_vld;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_cmd        = r_cmd;
        n_num        = r_num;
        n_cnt        = r_cnt;
        n_done       = 1'b0;
        n_status     = r_status;
        n_slot       = r_slot;
        n_res_num    = r_res_num;
        n_refs_after = r_refs_after;
        w_refs_we    = 1'b0;
        w_num_we     = 1'b0;
        w_wr_addr    = r_idx;
        w_wr_refs    = '0;
        w_res_idx    = r_cmp_idx;
        w_res_refs   = w_new_refs;

        case (r_state)
            S_CLEAR: begin
                w_refs_we = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            S_IDLE: begin
                if (start) begin
                    n_cmd = i_cmd;
                    n_cnt = i_release_count;
                    case (i_cmd)
                        rnt_pkg::CMD_ENTER:   n_num = w_enter_num;
                        rnt_pkg::CMD_ROOT:    n_num = rnt_pkg::ROOT_NUMBER;
                        rnt_pkg::CMD_RELEASE: n_num = i_node_number;
                        default:              n_num = '0;
                    endcase
                    if (i_cmd == rnt_pkg::CMD_UNUSED) begin
                        // Answered at once; the table is not touched.
                        n_done       = 1'b1;
                        n_status     = rnt_pkg::ST_UNKNOWN;
                        n_slot       = '0;
                        n_res_num    = '0;
                        n_refs_after = '0;
                    end else begin
                        n_state      = S_SCAN;
                        n_idx        = '0;
                        n_cmp_vld    = 1'b0;
                        n_free_found = 1'b0;
                    end
                end
            end

            S_SCAN: begin
                n_cmp_vld = 1'b1;
                n_cmp_idx = r_idx;
                if (r_idx != LAST_IDX) begin
                    n_idx = r_idx + IDX_W'(1);
                end
                if (r_cmp_vld) begin
                    if (w_flags.free && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_cmp_idx;
                    end
                    n_res_num = r_num;
                    if (w_flags.hit) begin
                        n_state   = S_IDLE;
                        n_done    = 1'b1;
                        w_wr_addr = r_cmp_idx;
                        w_wr_refs = w_new_refs;
                        if (w_over) begin
                            n_status     = rnt_pkg::ST_OVER;
                            n_slot       = '0;
                            w_res_refs   = r_refs_q;
                            n_refs_after = w_res_refs_ext[rnt_pkg::CNT_W-1:0];
                        end else begin
                            w_refs_we    = 1'b1;
                            n_status     = rnt_pkg::ST_EXISTING;
                            n_slot       = w_res_idx_ext[rnt_pkg::SLOT_W-1:0];
                            n_refs_after = w_res_refs_ext[rnt_pkg::CNT_W-1:0];
                        end
                    end else if (r_cmp_idx == LAST_IDX) begin
                        n_state      = S_IDLE;
                        n_done       = 1'b1;
                        n_slot       = '0;
                        n_refs_after = '0;
                        if (r_cmd == rnt_pkg::CMD_RELEASE) begin
                            n_status = rnt_pkg::ST_UNKNOWN;
                        end else if (r_free_found || w_flags.free) begin
                            // Lowest free slot, which may be the last one.
                            w_res_idx    = r_free_found ? r_free_idx : r_cmp_idx;
                            w_res_refs   = REF_BITS'(1);
                            w_wr_addr    = w_res_idx;
                            w_wr_refs    = REF_BITS'(1);
                            w_refs_we    = 1'b1;
                            w_num_we     = 1'b1;
                            n_status     = rnt_pkg::ST_NEW;
                            n_slot       = w_res_idx_ext[rnt_pkg::SLOT_W-1:0];
                            n_refs_after = w_res_refs_ext[rnt_pkg::CNT_W-1:0];
                        end else begin
                            n_status = rnt_pkg::ST_FULL;
                        end
                    end
                end
            end

            default: begin
                n_state = S_CLEAR;
                n_idx   = '0;
            end
        endcase
    end

    // Table memories: one write port and one registered read port each.
    always_ff @(posedge i_clk) begin
        if (w_refs_we) begin
            mem_refs[w_wr_addr] <= w_wr_refs;
        end
        if (w_num_we) begin
            mem_num[w_wr_addr] <= r_num;
        end
        r_num_q  <= mem_num[r_idx];
        r_refs_q <= mem_refs[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_idx        <= '0;
            r_cmp_vld    <= 1'b0;
            r_free_found <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_cmp_vld    <= n_cmp_vld;
            r_free_found <= n_free_found;
            r_done       <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx    <= n_cmp_idx;
        r_free_idx   <= n_free_idx;
        r_cmd        <= n_cmd;
        r_num        <= n_num;
        r_cnt        <= n_cnt;
        r_status     <= n_status;
        r_slot       <= n_slot;
        r_res_num    <= n_res_num;
        r_refs_after <= n_refs_after;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_slot          = r_slot;
    assign o_result_number = r_res_num;
    assign o_refs_after    = r_refs_after;

endmodule

### src/rnt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port checker for the reference-counted node table
// Watches the command and result ports and flags inconsistent beats.
// ----------------------------------------------------------------------------
module rnt_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [rnt_pkg::CMD_W-1:0]    i_cmd,
    input logic                         o_done,
    input logic [rnt_pkg::STATUS_W-1:0] o_status,
    input logic [rnt_pkg::SLOT_W-1:0]   o_slot,
    input logic [rnt_pkg::CNT_W-1:0]    o_refs_after
);

    // A table command that is taken makes the block busy.
    a_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_cmd != rnt_pkg::CMD_UNUSED) |=> busy)
        else $error("table command did not make the block busy");

    // The result beat is shown only once the block has gone idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while still busy");

    // Error results carry slot zero.
    a_err_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status == rnt_pkg::ST_FULL || o_status == rnt_pkg::ST_UNKNOWN ||
                   o_status == rnt_pkg::ST_OVER) |-> (o_slot == '0))
        else $error("error result with a nonzero slot");

    // A freshly allocated slot holds exactly one reference.
    a_new_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status == rnt_pkg::ST_NEW) |-> (o_refs_after == 16'd1))
        else $error("new slot does not hold one reference");

    // The unused command is answered in the next cycle.
    a_unused_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_cmd == rnt_pkg::CMD_UNUSED) |=>
            o_done && (o_status == rnt_pkg::ST_UNKNOWN))
        else $error("unused command not answered at once");

endmodule

bind refcounted_node_table rnt_checker u_rnt_checker (.*);
